/* rtl/ppc_pkg.sv */
// Package for the PID position corrector: word widths, register indexes,
// operation codes and the saturation helper. No dependencies.
package ppc_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int CfgIdxW   = 2;
  localparam int CntW      = 7;

  typedef logic signed [DataWidth-1:0] word_t;

  localparam logic [CfgIdxW-1:0] RegPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 2'd2;

  localparam logic OpStep = 1'b0;
  localparam logic OpInit = 1'b1;

  localparam logic signed [DataWidth+1:0] SMax =
    (DataWidth+2)'(signed'({1'b0, {(DataWidth-1){1'b1}}}));
  localparam logic signed [DataWidth+1:0] SMin = -SMax - (DataWidth+2)'(1);

  // Clip a sum that has grown by two bits into the word range.
  function automatic word_t sat_sum(input logic signed [DataWidth+1:0] v,
                                    output logic clipped);
    clipped = 1'b0;
    if (v > SMax) begin
      clipped = 1'b1;
      return word_t'(SMax);
    end
    if (v < SMin) begin
      clipped = 1'b1;
      return word_t'(SMin);
    end
    return v[DataWidth-1:0];
  endfunction
endpackage

/* rtl/ppc_mul.sv */
// Bit-serial signed fixed-point multiplier: floor((a*b) >> FracBits), clipped.
// One multiplier bit per cycle; b is one bit wider to carry unsigned words. Uses ppc_pkg.
module ppc_mul (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  ppc_pkg::word_t a_i,
  input  logic signed [ppc_pkg::DataWidth:0] b_i,
  output logic done_o,
  output ppc_pkg::word_t p_o,
  output logic sat_o
);
  import ppc_pkg::*;

  localparam int PW = 2*DataWidth;

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [PW-1:0]     acc_q;
  logic [PW-1:0]     mcand_q;
  logic [DataWidth:0] mplier_q;
  logic              neg_q;
  logic              done_q;
  word_t             p_q;
  logic              sat_q;

  logic [DataWidth-1:0] ma;
  logic [DataWidth:0]   mb;
  logic [PW-1:0]  acc_n;
  logic [PW-1:0]  qmag;
  logic           rest_nz;
  logic [PW-1:0]  limit;

  assign ma = a_i[DataWidth-1] ? DataWidth'(-a_i) : DataWidth'(a_i);
  assign mb = b_i[DataWidth] ? (DataWidth+1)'(-b_i) : (DataWidth+1)'(b_i);
  assign acc_n = mplier_q[0] ? acc_q + mcand_q : acc_q;

  always_comb begin
    rest_nz = |acc_q[FracBits-1:0];
    qmag    = acc_q >> FracBits;
    if (neg_q && rest_nz) qmag = qmag + PW'(1);
    limit   = neg_q ? PW'(SMax) + PW'(1) : PW'(SMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(DataWidth+1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= PW'(ma);
      mplier_q <= mb;
      neg_q    <= a_i[DataWidth-1] ^ b_i[DataWidth];
    end else if (busy_q && cnt_q != CntW'(DataWidth+1)) begin
      acc_q    <= acc_n;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end else if (busy_q) begin
      // final cycle: round, clip and sign the product
      if (qmag > limit) begin
        sat_q <= 1'b1;
        p_q   <= neg_q ? word_t'(SMin) : word_t'(SMax);
      end else begin
        sat_q <= 1'b0;
        p_q   <= neg_q ? word_t'(-qmag[DataWidth-1:0]) : word_t'(qmag[DataWidth-1:0]);
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;
  assign sat_o  = sat_q;
endmodule

/* rtl/ppc_div.sv */
// Restoring serial divider: (num << FracBits) / den, truncated toward zero,
// clipped to the word range. One quotient bit per cycle. Uses ppc_pkg.
module ppc_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [ppc_pkg::DataWidth:0] num_i,
  input  logic [ppc_pkg::DataWidth-1:0] den_i,
  output logic done_o,
  output ppc_pkg::word_t q_o,
  output logic sat_o
);
  import ppc_pkg::*;

  localparam int NW = DataWidth + 1 + FracBits;

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [NW-1:0]    num_q;
  logic [NW-1:0]    quo_q;
  logic [DataWidth:0] rem_q;
  logic [DataWidth-1:0] den_q;
  logic             neg_q;
  logic             done_q;
  word_t            q_q;
  logic             sat_q;

  logic [DataWidth:0] mag;
  logic [DataWidth+1:0] rem_sh;
  logic [DataWidth+1:0] rem_sub;
  logic [NW-1:0]   limit;

  assign mag     = num_i[DataWidth] ? (DataWidth+1)'(-num_i) : (DataWidth+1)'(num_i);
  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign rem_sub = rem_sh - (DataWidth+2)'(den_q);
  assign limit   = neg_q ? NW'(SMax) + NW'(1) : NW'(SMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NW)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag, {FracBits{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[DataWidth];
    end else if (busy_q && cnt_q != CntW'(NW)) begin
      num_q <= num_q << 1;
      if (!rem_sub[DataWidth+1]) begin
        rem_q <= rem_sub[DataWidth:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataWidth:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end else if (busy_q) begin
      if (quo_q > limit) begin
        sat_q <= 1'b1;
        q_q   <= neg_q ? word_t'(SMin) : word_t'(SMax);
      end else begin
        sat_q <= 1'b0;
        q_q   <= neg_q ? word_t'(-quo_q[DataWidth-1:0]) : word_t'(quo_q[DataWidth-1:0]);
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign sat_o  = sat_q;
endmodule

/* rtl/pid_position_corrector.sv */
// Channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
// item    | in        | in_valid/ready     | operation, error, loop_time, axis_position
// result  | out       | out_valid/ready    | delta, new_position, saturated
// A step raises the result after its transfer once four serial multiplies
// and the serial divide have run one after another, followed by the sums
// in StSum and StOut. With a zero interval the divide and D multiply are
// skipped. An init result comes the next cycle.
// The result register holds until taken; the next item is accepted the cycle
// after. Reset clears gains, previous error and integrated position.
// Top level; uses ppc_pkg, ppc_mul and ppc_div.
module pid_position_corrector (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [ppc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  ppc_pkg::word_t cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic operation_i,
  input  ppc_pkg::word_t error_i,
  input  logic [ppc_pkg::DataWidth-1:0] loop_time_i,
  input  ppc_pkg::word_t axis_position_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ppc_pkg::word_t delta_o,
  output ppc_pkg::word_t new_position_o,
  output logic saturated_o
);
  import ppc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMulP = 3'd1;
  localparam logic [2:0] StMulI = 3'd2;
  localparam logic [2:0] StMulT = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StMulD = 3'd5;
  localparam logic [2:0] StSum  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] st_q;
  word_t kp_q, ki_q, kd_q, prev_q, integ_q;
  word_t err_q, p_q, t_q, d_q;
  logic [DataWidth-1:0] dt_q;
  logic sat_q;
  logic out_valid_q;
  word_t delta_q, pos_q;
  logic out_sat_q;

  logic mul_start, mul_done, mul_sat;
  word_t mul_a, mul_p;
  logic signed [DataWidth:0] mul_b;
  logic div_start, div_done, div_sat;
  word_t div_q;
  logic signed [DataWidth:0] diff;

  logic  c_int, c_dl, c_ps;
  word_t int_n, delta_n, pos_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == StIdle) && !out_valid_q;
  assign diff = (DataWidth+1)'(err_q) - (DataWidth+1)'(prev_q);

  // Sign-extend signed words; zero-extend the unsigned loop time.
  always_comb begin
    mul_a = kp_q;
    mul_b = (DataWidth+1)'(err_q);
    case (st_q)
      StMulI:  begin mul_a = ki_q; mul_b = (DataWidth+1)'(err_q); end
      StMulT:  begin mul_a = t_q;  mul_b = signed'({1'b0, dt_q}); end
      StMulD:  begin mul_a = kd_q; mul_b = (DataWidth+1)'(div_q); end
      default: begin mul_a = kp_q; mul_b = (DataWidth+1)'(err_q); end
    endcase
  end

  ppc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p), .sat_o(mul_sat)
  );

  ppc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(diff), .den_i(dt_q),
    .done_o(div_done), .q_o(div_q), .sat_o(div_sat)
  );

  logic start_q;
  assign mul_start = start_q && (st_q == StMulP || st_q == StMulI ||
                                 st_q == StMulT || st_q == StMulD);
  assign div_start = start_q && (st_q == StDiv);

  always_comb begin
    int_n   = sat_sum((DataWidth+2)'(integ_q) + (DataWidth+2)'(t_q), c_int);
    delta_n = sat_sum((DataWidth+2)'(p_q) + (DataWidth+2)'(d_q), c_dl);
    pos_n   = sat_sum((DataWidth+2)'(p_q) + (DataWidth+2)'(integ_q)
                      + (DataWidth+2)'(d_q), c_ps);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      start_q <= 1'b0;
      out_valid_q <= 1'b0;
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      prev_q <= '0;
      integ_q <= '0;
    end else begin
      start_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegPropGain:  kp_q <= cfg_data_i;
          RegIntegGain: ki_q <= cfg_data_i;
          RegDerivGain: kd_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            if (operation_i == OpInit) begin
              integ_q <= axis_position_i;
              prev_q <= '0;
              delta_q <= '0;
              pos_q <= axis_position_i;
              out_sat_q <= 1'b0;
              out_valid_q <= 1'b1;
            end else begin
              err_q <= error_i;
              dt_q <= loop_time_i;
              sat_q <= 1'b0;
              d_q <= '0;
              st_q <= StMulP;
              start_q <= 1'b1;
            end
          end
        end
        StMulP: if (mul_done) begin
          p_q <= mul_p; sat_q <= sat_q | mul_sat;
          st_q <= StMulI; start_q <= 1'b1;
        end
        StMulI: if (mul_done) begin
          t_q <= mul_p; sat_q <= sat_q | mul_sat;
          st_q <= StMulT; start_q <= 1'b1;
        end
        StMulT: if (mul_done) begin
          t_q <= mul_p; sat_q <= sat_q | mul_sat;
          st_q <= StDiv; start_q <= 1'b1;
        end
        StDiv: begin
          if (start_q && dt_q == '0) begin
            st_q <= StSum;
          end else if (div_done) begin
            sat_q <= sat_q | div_sat;
            st_q <= StMulD; start_q <= 1'b1;
          end
        end
        StMulD: if (mul_done) begin
          d_q <= mul_p; sat_q <= sat_q | mul_sat;
          st_q <= StSum;
        end
        StSum: begin
          integ_q <= int_n;
          sat_q <= sat_q | c_int;
          st_q <= StOut;
        end
        StOut: begin
          delta_q <= delta_n;
          pos_q <= pos_n;
          out_sat_q <= sat_q | c_dl | c_ps;
          prev_q <= err_q;
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign delta_o        = delta_q;
  assign new_position_o = pos_q;
  assign saturated_o    = out_sat_q;
endmodule
